### design/numeric_literal_scanner_defines.svh
`ifndef NUMERIC_LITERAL_SCANNER_DEFINES_SVH
`define NUMERIC_LITERAL_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define NLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("numeric_literal_scanner: check failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define NLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("numeric_literal_scanner: check failed");

`endif

### design/nls_pkg.sv
`timescale 1ns / 1ps

package nls_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int OFF_W        = 16;
  localparam int RES_MAX      = 3;
  localparam int RCNT_W       = $clog2(RES_MAX + 1);
  localparam int RES_DEPTH    = 4;
  localparam int PTR_W        = $clog2(RES_DEPTH);
  localparam int FREE_W       = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_LX         = 8'h78;
  localparam logic [7:0] CH_UX         = 8'h58;
  localparam logic [7:0] CH_LB         = 8'h62;
  localparam logic [7:0] CH_UB         = 8'h42;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_LE         = 8'h65;
  localparam logic [7:0] CH_UE         = 8'h45;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_ONE        = 8'h31;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ZERO = 4'd1,
    PH_DEC  = 4'd2,
    PH_DOT  = 4'd3,
    PH_FRAC = 4'd4,
    PH_EXPE = 4'd5,
    PH_EXP  = 4'd6,
    PH_HEX  = 4'd7,
    PH_BIN  = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    EV_SEP   = 2'd0,
    EV_NODIG = 2'd1,
    EV_DONE  = 2'd2
  } event_e;

  typedef struct packed {
    phase_e phase;
    logic   any_digit;
    logic   prev_digit;
    logic   prev_separator;
    logic   float_seen;
  } ctl_t;

  typedef struct packed {
    event_e           ev;
    logic [OFF_W-1:0] at_offset;
    logic             float_lit;
    logic [OFF_W-1:0] length;
    logic             last;
  } res_t;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_e(input logic [7:0] c);
    return (c == CH_LE) || (c == CH_UE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

### design/numeric_literal_scanner.sv
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   ch_i, first_i, end_of_text_i
// out      out_valid_o/out_ready_i event_res_o, at_offset_o, float_lit_o, length_o, last_o
//
// An input word is registered, then classified in one pass that updates the
// literal state and pushes zero to three result words into a four-entry result
// queue; the queue sets the pace, one result word per cycle while out_ready_i is high.
// The input register takes a new word while the held word is classified.
// Reset clears the state, the input register and the queue.
// The input register drains only while the queue has room for three words.
`timescale 1ns / 1ps
`include "numeric_literal_scanner_defines.svh"

module numeric_literal_scanner #(
  parameter int POS_BITS = nls_pkg::POS_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                ch_i,
  input  logic                      first_i,
  input  logic                      end_of_text_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                event_res_o,
  output logic [nls_pkg::OFF_W-1:0] at_offset_o,
  output logic                      float_lit_o,
  output logic [nls_pkg::OFF_W-1:0] length_o,
  output logic                      last_o
);

  logic                       inq_valid_q;
  logic [7:0]                 inq_ch_q;
  logic                       inq_first_q;
  logic                       inq_eot_q;
  nls_pkg::ctl_t              ctl_q, ctl_d;
  logic [POS_BITS-1:0]        pos_q, pos_d;
  nls_pkg::res_t              step_res [nls_pkg::RES_MAX];
  logic [nls_pkg::RCNT_W-1:0] step_cnt;
  logic [nls_pkg::RCNT_W-1:0] push_cnt;
  logic [nls_pkg::FREE_W-1:0] fifo_free;
  nls_pkg::res_t              head;
  logic                       proc;
  logic                       stray_char;

  assign proc       = inq_valid_q && (fifo_free >= nls_pkg::FREE_W'(nls_pkg::RES_MAX));
  assign in_ready_o = !inq_valid_q || proc;
  assign push_cnt   = proc ? step_cnt : '0;
  assign stray_char = (ctl_q.phase == nls_pkg::PH_IDLE) && !inq_first_q && !inq_eot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_ch_q    <= ch_i;
      inq_first_q <= first_i;
      inq_eot_q   <= end_of_text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{nls_pkg::PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0};
      pos_q <= '0;
    end else if (proc) begin
      ctl_q <= ctl_d;
      pos_q <= pos_d;
    end
  end

  nls_step #(
    .POS_BITS(POS_BITS)
  ) u_step (
    .ch_i    (inq_ch_q),
    .first_i (inq_first_q),
    .eot_i   (inq_eot_q),
    .ctl_i   (ctl_q),
    .pos_i   (pos_q),
    .ctl_o   (ctl_d),
    .pos_o   (pos_d),
    .res_o   (step_res),
    .cnt_o   (step_cnt)
  );

  nls_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_i     (step_res),
    .pop_i      (out_ready_i),
    .valid_o    (out_valid_o),
    .head_o     (head),
    .free_o     (fifo_free)
  );

  assign event_res_o = head.ev;
  assign at_offset_o = head.at_offset;
  assign float_lit_o = head.float_lit;
  assign length_o    = head.length;
  assign last_o      = head.last;

  `NLS_ASSERT_NOW(a_done_is_last, out_valid_o && event_res_o == nls_pkg::EV_DONE, last_o)
  `NLS_ASSERT_NOW(a_stray_silent, proc && stray_char, step_cnt == '0)
  `NLS_ASSERT_NEXT(a_eot_closes, proc && inq_eot_q, ctl_q.phase == nls_pkg::PH_IDLE)

endmodule

### design/nls_step.sv
`timescale 1ns / 1ps

module nls_step #(
  parameter int POS_BITS = nls_pkg::POS_BITS_DEF
) (
  input  logic [7:0]                 ch_i,
  input  logic                       first_i,
  input  logic                       eot_i,
  input  nls_pkg::ctl_t              ctl_i,
  input  logic [POS_BITS-1:0]        pos_i,
  output nls_pkg::ctl_t              ctl_o,
  output logic [POS_BITS-1:0]        pos_o,
  output nls_pkg::res_t              res_o [nls_pkg::RES_MAX],
  output logic [nls_pkg::RCNT_W-1:0] cnt_o
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  function automatic logic [nls_pkg::OFF_W-1:0] lo_off(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+nls_pkg::OFF_W-1:0] ext;
    ext = (POS_BITS + nls_pkg::OFF_W)'(v);
    return ext[nls_pkg::OFF_W-1:0];
  endfunction

  nls_pkg::ctl_t             c;
  logic [POS_BITS-1:0]       pos;
  logic [nls_pkg::RCNT_W-1:0] n;
  logic                      run_ph;
  logic                      in_set;
  logic                      taken;
  nls_pkg::res_t             res [nls_pkg::RES_MAX];

  always_comb begin
    c      = ctl_i;
    pos    = pos_i;
    n      = '0;
    taken  = 1'b0;
    run_ph = 1'b0;
    in_set = 1'b0;
    for (int k = 0; k < nls_pkg::RES_MAX; k++) begin
      res[k] = '0;
    end

    // close any open literal
    if ((eot_i || first_i) && (c.phase != nls_pkg::PH_IDLE)) begin
      if (c.phase inside {nls_pkg::PH_DEC, nls_pkg::PH_FRAC, nls_pkg::PH_EXP,
                          nls_pkg::PH_HEX, nls_pkg::PH_BIN}) begin
        if (c.prev_separator && (pos != '0)) begin
          res[n] = '{nls_pkg::EV_SEP, lo_off(pos - POS_ONE), 1'b0, '0, 1'b0};
          n = n + 1'b1;
        end
        if (!c.any_digit) begin
          res[n] = '{nls_pkg::EV_NODIG, lo_off(pos), 1'b0, '0, 1'b0};
          n = n + 1'b1;
        end
      end
      res[n] = '{nls_pkg::EV_DONE, '0, c.float_seen, lo_off(pos), 1'b0};
      n = n + 1'b1;
      c.phase = nls_pkg::PH_IDLE;
    end

    if (!eot_i && first_i) begin
      pos = POS_ONE;
      c.float_seen     = 1'b0;
      c.any_digit      = 1'b1;
      c.prev_digit     = 1'b1;
      c.prev_separator = 1'b0;
      c.phase = (ch_i == nls_pkg::CH_ZERO) ? nls_pkg::PH_ZERO : nls_pkg::PH_DEC;
    end else if (!eot_i && (c.phase != nls_pkg::PH_IDLE)) begin
      if (c.phase == nls_pkg::PH_ZERO) begin
        if (ch_i inside {nls_pkg::CH_LX, nls_pkg::CH_UX, nls_pkg::CH_LB, nls_pkg::CH_UB}) begin
          if (pos != POS_MAX) pos = pos + POS_ONE;
          c.any_digit      = 1'b0;
          c.prev_digit     = 1'b0;
          c.prev_separator = 1'b0;
          c.phase = (ch_i == nls_pkg::CH_LX || ch_i == nls_pkg::CH_UX) ?
                    nls_pkg::PH_HEX : nls_pkg::PH_BIN;
          taken = 1'b1;
        end else begin
          c.phase = nls_pkg::PH_DEC;
        end
      end

      run_ph = c.phase inside {nls_pkg::PH_DEC, nls_pkg::PH_FRAC, nls_pkg::PH_EXP,
                               nls_pkg::PH_HEX, nls_pkg::PH_BIN};
      case (c.phase)
        nls_pkg::PH_HEX: in_set = nls_pkg::is_hex(ch_i);
        nls_pkg::PH_BIN: in_set = (ch_i == nls_pkg::CH_ZERO) || (ch_i == nls_pkg::CH_ONE);
        default:         in_set = nls_pkg::is_dec(ch_i);
      endcase
      in_set = in_set || (ch_i == nls_pkg::CH_UNDERSCORE);

      if (taken) begin
        c = c;
      end else if (run_ph) begin
        if (in_set) begin
          if (ch_i == nls_pkg::CH_UNDERSCORE) begin
            if (!c.prev_digit) begin
              res[n] = '{nls_pkg::EV_SEP, lo_off(pos), 1'b0, '0, 1'b0};
              n = n + 1'b1;
            end
            c.prev_digit     = 1'b0;
            c.prev_separator = 1'b1;
          end else begin
            c.any_digit      = 1'b1;
            c.prev_digit     = 1'b1;
            c.prev_separator = 1'b0;
          end
          if (pos != POS_MAX) pos = pos + POS_ONE;
        end else begin
          if (c.prev_separator && (pos != '0)) begin
            res[n] = '{nls_pkg::EV_SEP, lo_off(pos - POS_ONE), 1'b0, '0, 1'b0};
            n = n + 1'b1;
          end
          if (!c.any_digit) begin
            res[n] = '{nls_pkg::EV_NODIG, lo_off(pos), 1'b0, '0, 1'b0};
            n = n + 1'b1;
          end
          if (c.phase == nls_pkg::PH_DEC && ch_i == nls_pkg::CH_DOT) begin
            c.phase = nls_pkg::PH_DOT;
          end else if ((c.phase == nls_pkg::PH_DEC || c.phase == nls_pkg::PH_FRAC) &&
                       nls_pkg::is_e(ch_i)) begin
            c.phase = nls_pkg::PH_EXPE;
          end else begin
            res[n] = '{nls_pkg::EV_DONE, '0, c.float_seen, lo_off(pos), 1'b0};
            n = n + 1'b1;
            c.phase = nls_pkg::PH_IDLE;
          end
        end
      end else if (c.phase == nls_pkg::PH_DOT || c.phase == nls_pkg::PH_EXPE) begin
        if (nls_pkg::is_dec(ch_i) ||
            (c.phase == nls_pkg::PH_EXPE && nls_pkg::is_sign(ch_i))) begin
          if (pos != POS_MAX) pos = pos + POS_ONE;
          c.float_seen     = 1'b1;
          c.prev_separator = 1'b0;
          c.any_digit      = nls_pkg::is_dec(ch_i);
          c.prev_digit     = nls_pkg::is_dec(ch_i);
          c.phase = (c.phase == nls_pkg::PH_DOT) ? nls_pkg::PH_FRAC : nls_pkg::PH_EXP;
          if (pos != POS_MAX) pos = pos + POS_ONE;
        end else begin
          res[n] = '{nls_pkg::EV_DONE, '0, c.float_seen, lo_off(pos), 1'b0};
          n = n + 1'b1;
          c.phase = nls_pkg::PH_IDLE;
        end
      end else begin
        c.phase = nls_pkg::PH_IDLE;
      end
    end else begin
      run_ph = 1'b0;
      in_set = 1'b0;
    end

    // flag final word of this item
    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
  end

  assign ctl_o = c;
  assign pos_o = pos;
  assign res_o = res;
  assign cnt_o = n;

endmodule

### design/nls_fifo.sv
`timescale 1ns / 1ps

module nls_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [nls_pkg::RCNT_W-1:0] push_cnt_i,
  input  nls_pkg::res_t              push_i [nls_pkg::RES_MAX],
  input  logic                       pop_i,
  output logic                       valid_o,
  output nls_pkg::res_t              head_o,
  output logic [nls_pkg::FREE_W-1:0] free_o
);

  logic [nls_pkg::PTR_W-1:0]  wr_q;
  logic [nls_pkg::PTR_W-1:0]  rd_q;
  logic [nls_pkg::FREE_W-1:0] cnt_q;
  nls_pkg::res_t              mem_q [nls_pkg::RES_DEPTH];
  logic                       pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign free_o  = nls_pkg::FREE_W'(nls_pkg::RES_DEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < nls_pkg::RES_MAX; k++) begin
      if (nls_pkg::RCNT_W'(k) < push_cnt_i) begin
        mem_q[wr_q + nls_pkg::PTR_W'(k)] <= push_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + nls_pkg::PTR_W'(push_cnt_i);
      rd_q  <= rd_q + nls_pkg::PTR_W'(pop);
      cnt_q <= cnt_q + nls_pkg::FREE_W'(push_cnt_i) - nls_pkg::FREE_W'(pop);
    end
  end

endmodule
